>>> src/scss_pkg.sv
// ----------------------------------------------------------------------------
// Six-channel stepper sequencer package
// Shared constants, codes, microcode table and helper functions.
// ----------------------------------------------------------------------------
package scss_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int PHASES       = 4;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PH_W         = $clog2(PHASES);
  localparam int STEP_W       = 16;
  localparam int TICK_W       = 16;
  localparam int PATTERN_W    = 8;
  localparam int BYTE_W       = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [BYTE_W-1:0] STROBE_BIT = 8'h01;

  typedef enum logic [3:0] {
    CMD_TICK   = 4'd0,
    CMD_LOAD   = 4'd1,
    CMD_START  = 4'd2,
    CMD_PAUSE  = 4'd3,
    CMD_RESUME = 4'd4,
    CMD_STOP   = 4'd5,
    CMD_CLEAR  = 4'd6,
    CMD_TORQUE = 4'd7,
    CMD_READ   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_REFUSED     = 2'd1,
    ST_BAD_CHANNEL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RUN_STOPPED = 2'd0,
    RUN_RUNNING = 2'd1,
    RUN_PAUSED  = 2'd2
  } run_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TICK_PERIOD  = 1'b0,
    CFG_FREE_PATTERN = 1'b1
  } cfg_reg_t;

  // Microprogram addresses.
  typedef enum logic [1:0] {
    UA_QUIET   = 2'd0,
    UA_PULSE   = 2'd1,
    UA_RELEASE = 2'd2,
    UA_IDLE    = 2'd3
  } uaddr_t;

  // What a control word puts into the output register.
  typedef enum logic [1:0] {
    EMIT_QUIET    = 2'd0,
    EMIT_STROBE   = 2'd1,
    EMIT_UNSTROBE = 2'd2,
    EMIT_IDLE     = 2'd3
  } emit_t;

  // How the step counter moves after a control word.
  typedef enum logic [1:0] {
    SEQ_END  = 2'd0,
    SEQ_NEXT = 2'd1,
    SEQ_CHAN = 2'd2
  } seq_t;

  typedef struct packed {
    emit_t emit;
    seq_t  seq;
  } cword_t;

  typedef struct packed {
    logic more_ch;
    logic idle_pend;
  } useq_cond_t;

  function automatic cword_t ucode_rom(uaddr_t addr);
    cword_t w;
    case (addr)
      UA_QUIET:   w = '{emit: EMIT_QUIET,    seq: SEQ_END};
      UA_PULSE:   w = '{emit: EMIT_STROBE,   seq: SEQ_NEXT};
      UA_RELEASE: w = '{emit: EMIT_UNSTROBE, seq: SEQ_CHAN};
      UA_IDLE:    w = '{emit: EMIT_IDLE,     seq: SEQ_END};
      default:    w = '{emit: EMIT_QUIET,    seq: SEQ_END};
    endcase
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] coil_of(logic [PH_W-1:0] ph);
    logic [BYTE_W-1:0] c;
    case (ph)
      2'd0:    c = 8'd192;
      2'd1:    c = 8'd144;
      2'd2:    c = 8'd48;
      2'd3:    c = 8'd96;
      default: c = 8'd192;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] chan_addr(logic [CH_W-1:0] idx);
    logic [BYTE_W-1:0] a;
    a = BYTE_W'(idx) + BYTE_W'(1);
    return a << 1;
  endfunction

  function automatic logic [CH_W-1:0] first_set(logic [NUM_CHANNELS-1:0] m);
    logic [CH_W-1:0] r;
    r = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (m[i]) r = CH_W'(i);
    end
    return r;
  endfunction

endpackage

>>> src/six_channel_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// Six-channel stepper sequencer
// Full-step controller for stepper channels sharing one 8-bit arm port.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    command, channel, steps, torque_on
//   out      output     out_valid / out_stall  port_valid, port_byte, position,
//                                              status, run_state_out, last
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// Each item runs a microprogram that loads one result beat per cycle, while the
// output is not stalled, into the output register: 13 beats for a torque
// command, two per stepping channel plus an idle beat when the last steps run
// out for a stepping tick (at most 13), and one beat otherwise. A new item is
// accepted only once the final beat of the last one has been loaded.
// Reset clears all channel state, the run state and the tick count; a stalled
// output holds the sequencer in place.
module six_channel_stepper_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [3:0]                           command,
  input  logic [2:0]                           channel,
  input  logic signed [scss_pkg::STEP_W-1:0]   steps,
  input  logic                                 torque_on,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 port_valid,
  output logic [scss_pkg::BYTE_W-1:0]          port_byte,
  output logic signed [scss_pkg::STEP_W-1:0]   position,
  output logic [1:0]                           status,
  output logic [1:0]                           run_state_out,
  output logic                                 last,
  input  logic                                 cfg_we,
  input  logic [scss_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [scss_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import scss_pkg::*;

  // Configuration and channel state.
  logic [TICK_W-1:0]    tick_period;
  logic [PATTERN_W-1:0] free_pattern;
  logic [STEP_W-1:0]    remaining_steps [NUM_CHANNELS];
  logic                 direction       [NUM_CHANNELS];
  logic [PH_W-1:0]      phase_index     [NUM_CHANNELS];
  logic [STEP_W-1:0]    position_count  [NUM_CHANNELS];
  run_t                 run_state;
  logic [TICK_W-1:0]    elapsed_ticks;

  // Per-item sequencing registers.
  logic                    mode_tick;
  logic                    torque_flag;
  logic                    pos_en;
  status_t                 res_status;
  logic                    idle_pend;
  logic [NUM_CHANNELS-1:0] chan_mask;
  logic [CH_W-1:0]         ch_idx;

  cmd_t                    cmd_in;
  logic                    ch_ok;
  logic [CH_W-1:0]         ch_in_idx;
  logic                    accept;
  logic                    fire;
  logic                    busy;
  cword_t                  cw;
  useq_cond_t              cond;
  uaddr_t                  entry;

  logic [TICK_W-1:0]       elapsed_inc;
  logic                    step_due;
  logic [NUM_CHANNELS-1:0] busy_mask;
  logic                    any_left;
  logic [NUM_CHANNELS-1:0] mask_sel;
  logic                    idle_sel;

  logic [NUM_CHANNELS-1:0] mask_left;
  logic [STEP_W-1:0]       cur_rem;
  logic [PH_W-1:0]         cur_phase;
  logic [PH_W-1:0]         new_phase;
  logic [STEP_W-1:0]       cur_pos;
  logic [STEP_W-1:0]       new_pos;
  logic [BYTE_W-1:0]       coil;
  logic [BYTE_W-1:0]       byte_base;

  logic                    res_valid;
  logic [BYTE_W-1:0]       res_byte;
  logic [STEP_W-1:0]       res_pos;
  status_t                 res_st;
  logic                    res_last;

  assign cmd_in    = cmd_t'(command);
  assign ch_ok     = (channel >= 3'd1) && (channel <= 3'(NUM_CHANNELS));
  assign ch_in_idx = CH_W'(channel - 3'd1);
  assign in_stall  = busy;
  assign accept    = in_valid && !in_stall;
  assign fire      = busy && (!out_valid || !out_stall);

  // Tick bookkeeping and the set of channels that step on this tick.
  always_comb begin
    elapsed_inc = (elapsed_ticks == {TICK_W{1'b1}}) ? elapsed_ticks
                                                     : elapsed_ticks + TICK_W'(1);
    step_due    = (run_state == RUN_RUNNING) && (elapsed_inc >= tick_period);
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      busy_mask[i] = (remaining_steps[i] != '0);
    end
    // A channel keeps steps after this tick only if it holds two or more now.
    any_left = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (remaining_steps[i] > STEP_W'(1)) any_left = 1'b1;
    end
  end

  always_comb begin
    mask_sel = '0;
    idle_sel = 1'b0;
    entry    = UA_QUIET;
    case (cmd_in)
      CMD_TICK: begin
        if (step_due) begin
          mask_sel = busy_mask;
          idle_sel = !any_left;
          entry    = (|busy_mask) ? UA_PULSE : UA_IDLE;
        end
      end
      CMD_TORQUE: begin
        mask_sel = '1;
        idle_sel = 1'b1;
        entry    = UA_PULSE;
      end
      default: begin
        entry = UA_QUIET;
      end
    endcase
  end

  scss_useq u_useq (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .entry   (entry),
    .advance (fire),
    .cond    (cond),
    .busy    (busy),
    .cw      (cw)
  );

  // Channel datapath at the channel the sequencer points to.
  always_comb begin
    mask_left = chan_mask & ~(NUM_CHANNELS'(1) << ch_idx);
    cond      = '{more_ch: |mask_left, idle_pend: idle_pend};
    cur_rem   = remaining_steps[ch_idx];
    cur_phase = phase_index[ch_idx];
    cur_pos   = position_count[ch_idx];
    if (direction[ch_idx]) begin
      new_phase = cur_phase + PH_W'(1);
      new_pos   = cur_pos + STEP_W'(1);
    end else begin
      new_phase = cur_phase - PH_W'(1);
      new_pos   = cur_pos - STEP_W'(1);
    end

    if (mode_tick) begin
      // The strobed beat of a step already shows the new phase.
      coil = (cw.emit == EMIT_STROBE) ? coil_of(new_phase) : coil_of(cur_phase);
    end else begin
      coil = torque_flag ? coil_of(cur_phase) : free_pattern;
    end
    byte_base = coil + chan_addr(ch_idx);

    res_valid = 1'b1;
    res_byte  = '0;
    res_pos   = '0;
    res_st    = ST_OK;
    res_last  = 1'b0;
    case (cw.emit)
      EMIT_QUIET: begin
        res_valid = 1'b0;
        res_pos   = pos_en ? cur_pos : '0;
        res_st    = res_status;
        res_last  = 1'b1;
      end
      EMIT_STROBE: begin
        res_byte = byte_base + STROBE_BIT;
      end
      EMIT_UNSTROBE: begin
        res_byte = byte_base;
        res_last = !cond.more_ch && !idle_pend;
      end
      EMIT_IDLE: begin
        res_byte = STROBE_BIT;
        res_last = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
        res_last  = 1'b1;
      end
    endcase
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period   <= TICK_W'(12);
      free_pattern  <= '0;
      run_state     <= RUN_STOPPED;
      elapsed_ticks <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        remaining_steps[i] <= '0;
        direction[i]       <= 1'b0;
        phase_index[i]     <= '0;
        position_count[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TICK_PERIOD:  tick_period  <= cfg_data;
          CFG_FREE_PATTERN: free_pattern <= cfg_data[PATTERN_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        case (cmd_in)
          CMD_TICK: begin
            if (step_due) begin
              elapsed_ticks <= '0;
              if (!any_left) run_state <= RUN_STOPPED;
            end else begin
              elapsed_ticks <= elapsed_inc;
            end
          end
          CMD_LOAD: begin
            if (ch_ok) begin
              remaining_steps[ch_in_idx] <= steps[STEP_W-1] ? $unsigned(-steps)
                                                            : $unsigned(steps);
              direction[ch_in_idx]       <= !steps[STEP_W-1] && (steps != '0);
            end
          end
          CMD_START: begin
            run_state <= RUN_RUNNING;
          end
          CMD_PAUSE: begin
            if (run_state == RUN_RUNNING) run_state <= RUN_PAUSED;
          end
          CMD_RESUME: begin
            if (run_state == RUN_PAUSED) run_state <= RUN_RUNNING;
          end
          CMD_STOP: begin
            run_state <= RUN_STOPPED;
          end
          CMD_CLEAR: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              position_count[i] <= '0;
            end
          end
          default: ;
        endcase
      end

      if (fire && (cw.emit == EMIT_STROBE) && mode_tick) begin
        phase_index[ch_idx]     <= new_phase;
        position_count[ch_idx]  <= new_pos;
        remaining_steps[ch_idx] <= cur_rem - STEP_W'(1);
      end
    end
  end

  // Per-item sequencing registers; only read while the sequencer is busy.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_tick   <= (cmd_in == CMD_TICK);
      torque_flag <= torque_on;
      pos_en      <= (cmd_in == CMD_READ) && ch_ok;
      idle_pend   <= idle_sel;
      chan_mask   <= mask_sel;
      ch_idx      <= (cmd_in == CMD_READ) ? ch_in_idx : first_set(mask_sel);
      case (cmd_in)
        CMD_LOAD, CMD_READ: res_status <= ch_ok ? ST_OK : ST_BAD_CHANNEL;
        CMD_PAUSE, CMD_RESUME: begin
          res_status <= (run_state == RUN_STOPPED) ? ST_REFUSED : ST_OK;
        end
        default: res_status <= ST_OK;
      endcase
    end else if (fire && (cw.emit == EMIT_UNSTROBE)) begin
      chan_mask <= mask_left;
      ch_idx    <= first_set(mask_left);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      port_valid    <= res_valid;
      port_byte     <= res_byte;
      position      <= $signed(res_pos);
      status        <= res_st;
      run_state_out <= run_state;
      last          <= res_last;
    end
  end

  // A new item always occupies the sequencer on the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("sequencer not busy after an accepted item");

  // The final beat of an item ends the microprogram.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    fire && res_last |=> !busy)
    else $error("sequencer still busy after the final beat");

  // Only channels with steps left are pulsed on a tick.
  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    fire && (cw.emit == EMIT_STROBE) && mode_tick |-> cur_rem != '0)
    else $error("stepping a channel with no steps left");

  // A non-final beat never leaves the sequencer idle.
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    fire && !res_last |=> busy)
    else $error("sequencer stopped before the final beat");

endmodule

>>> src/scss_useq.sv
// ----------------------------------------------------------------------------
// Microprogram sequencer
// Step counter over the control store, with the channel loop jump.
// ----------------------------------------------------------------------------
module scss_useq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  scss_pkg::uaddr_t    entry,
  input  logic                advance,
  input  scss_pkg::useq_cond_t cond,
  output logic                busy,
  output scss_pkg::cword_t    cw
);
  import scss_pkg::*;

  uaddr_t pc;
  uaddr_t pc_next;
  logic   busy_next;

  assign cw = ucode_rom(pc);

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = entry;
      busy_next = 1'b1;
    end else if (busy && advance) begin
      case (cw.seq)
        SEQ_END: begin
          busy_next = 1'b0;
        end
        SEQ_NEXT: begin
          pc_next = uaddr_t'(pc + 2'd1);
        end
        SEQ_CHAN: begin
          // Loop back while channels remain, then the idle beat if one is owed.
          if (cond.more_ch) begin
            pc_next = UA_PULSE;
          end else if (cond.idle_pend) begin
            pc_next = UA_IDLE;
          end else begin
            busy_next = 1'b0;
          end
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= UA_QUIET;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

endmodule
